>>> rtl/core/derd_pkg.sv
// Shared types, constants and header layout decode for the event record decoder.
`default_nettype none

package derd_pkg;

    // Header bytes that carry fields; the rest of the header is skipped.
    localparam int HDR_USED = 34;

    // Entries in the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Header field numbers, in the order in which they complete.
    localparam logic [3:0] FLD_DATA_LENGTH   = 4'd0;
    localparam logic [3:0] FLD_RUN_NUMBER    = 4'd1;
    localparam logic [3:0] FLD_TRIG_TYPE     = 4'd2;
    localparam logic [3:0] FLD_TRIG_NUMBER   = 4'd3;
    localparam logic [3:0] FLD_TRIG_TIME     = 4'd4;
    localparam logic [3:0] FLD_MODULE_ID     = 4'd5;
    localparam logic [3:0] FLD_LOCAL_NUMBER  = 4'd6;
    localparam logic [3:0] FLD_LOCAL_PATTERN = 4'd7;
    localparam logic [3:0] FLD_LOCAL_TIME    = 4'd8;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_FAST   = 2'd1,
        KIND_WAVE   = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        OP_SKIP       = 3'd0,
        OP_FINE       = 3'd1,
        OP_HEADER     = 3'd2,
        OP_LOW        = 3'd3,
        OP_ENERGY_LO  = 3'd4,
        OP_ENERGY_HI  = 3'd5,
        OP_FAST_EMIT  = 3'd6,
        OP_WAVE_EMIT  = 3'd7
    } op_code_t;

    // One classified byte, as passed from the front part to the back part.
    typedef struct packed {
        op_code_t    op;
        logic [7:0]  data;
        logic        hdr_first;
        logic        hdr_emit;
        logic        hdr_time;
        logic [2:0]  shift;
        logic [9:0]  field_code;
        logic [5:0]  channel;
        logic        last;
    } derd_op_t;

    typedef struct packed {
        logic        used;
        logic        fine;
        logic        first;
        logic        emit;
        logic        is_time;
        logic [2:0]  shift;
        logic [3:0]  field;
    } hdr_info_t;

    // Maps a header byte position to the field it belongs to.
    function automatic hdr_info_t hdr_decode(input logic [5:0] p);
        hdr_info_t  h;
        logic [5:0] first_pos;
        logic [5:0] last_pos;
        logic [5:0] rel;
        h         = '0;
        first_pos = '0;
        last_pos  = '0;
        case (p) inside
            [6'd0:6'd3]:
            begin
                h.used = 1'b1; h.field = FLD_DATA_LENGTH;
                first_pos = 6'd0; last_pos = 6'd3;
            end
            [6'd4:6'd5]:
            begin
                h.used = 1'b1; h.field = FLD_RUN_NUMBER;
                first_pos = 6'd4; last_pos = 6'd5;
            end
            6'd6:
            begin
                h.used = 1'b1; h.field = FLD_TRIG_TYPE;
                first_pos = 6'd6; last_pos = 6'd6;
            end
            [6'd7:6'd10]:
            begin
                h.used = 1'b1; h.field = FLD_TRIG_NUMBER;
                first_pos = 6'd7; last_pos = 6'd10;
            end
            [6'd12:6'd17]:
            begin
                h.used = 1'b1; h.field = FLD_TRIG_TIME; h.is_time = 1'b1;
                first_pos = 6'd12; last_pos = 6'd17;
            end
            6'd18:
            begin
                h.used = 1'b1; h.field = FLD_MODULE_ID;
                first_pos = 6'd18; last_pos = 6'd18;
            end
            [6'd19:6'd22]:
            begin
                h.used = 1'b1; h.field = FLD_LOCAL_NUMBER;
                first_pos = 6'd19; last_pos = 6'd22;
            end
            [6'd23:6'd26]:
            begin
                h.used = 1'b1; h.field = FLD_LOCAL_PATTERN;
                first_pos = 6'd23; last_pos = 6'd26;
            end
            [6'd28:6'd33]:
            begin
                h.used = 1'b1; h.field = FLD_LOCAL_TIME; h.is_time = 1'b1;
                first_pos = 6'd28; last_pos = 6'd33;
            end
            6'd11, 6'd27:
            begin
                h.fine = 1'b1;
            end
            default:
            begin
                h.used = 1'b0;
            end
        endcase
        rel     = p - first_pos;
        h.shift = rel[2:0];
        h.first = h.used && (p == first_pos);
        h.emit  = h.used && (p == last_pos);
        return h;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/daq_event_record_decoder.sv
// Top level of the detector readout record decoder.
//
// Raw record bytes enter on the byte channel (byte_valid, byte_stall,
// data_byte); a byte is transferred at a rising edge with byte_valid high and
// byte_stall low. Decoded results leave on the result channel under the same
// rules, with result_stall driven by the receiver. A result passes from the
// queue through the execute stage into the output register, where it
// becomes valid and waits for its own transfer.
// The block takes one byte per cycle while byte_stall is low; a header
// field, fast channel or waveform sample completes on a single byte, so
// results also stream at up to one per cycle while result_stall is low.
// The record_mode register is written through cfg_write and cfg_data; the
// user must write it only while the block is idle, which the block itself
// does not enforce. A write restarts the record at byte 0.
// Reset selects fast mode, returns to the start of a record and empties the
// queue and pipeline. When the receiver stalls, the output register holds its
// result, the execute stage and the four-entry queue fill behind it, and
// byte_stall rises once the queue is full.
`default_nettype none

module daq_event_record_decoder #(
    parameter int CHANNELS     = 32,
    parameter int HEADER_BYTES = 64,
    parameter int WAVE_SAMPLES = 1023
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 cfg_write,
    input  wire                 cfg_data,
    input  wire                 byte_valid,
    output logic                byte_stall,
    input  wire  [7:0]          data_byte,
    output logic                result_valid,
    input  wire                 result_stall,
    output logic [1:0]          item_kind,
    output logic [9:0]          field_code,
    output logic [5:0]          channel,
    output logic [57:0]         value,
    output logic [15:0]         timing,
    output logic signed [15:0]  sample,
    output logic                last_of_record
);
    import derd_pkg::*;

    logic      byte_accept;
    logic      queue_full;
    logic      head_valid;
    logic      head_pop;
    derd_op_t  front_op;
    derd_op_t  head_op;

    // The queue is the only source of back-pressure on the byte channel, so
    // byte_stall comes straight from its fill count.
    assign byte_stall  = queue_full;
    assign byte_accept = byte_valid && !byte_stall;

    // Front part: position tracking and byte classification.
    derd_front #(
        .CHANNELS     (CHANNELS),
        .HEADER_BYTES (HEADER_BYTES),
        .WAVE_SAMPLES (WAVE_SAMPLES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .accept    (byte_accept),
        .data_byte (data_byte),
        .op        (front_op)
    );

    // Every transferred byte goes into the queue, including skipped ones, so
    // the front never waits on the back beyond the queue depth.
    derd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (byte_accept),
        .push_op    (front_op),
        .full       (queue_full),
        .pop        (head_pop),
        .head_valid (head_valid),
        .head_op    (head_op)
    );

    // Back part: field assembly, time scaling and the output register.
    derd_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .op_valid       (head_valid),
        .op             (head_op),
        .op_pop         (head_pop),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .item_kind      (item_kind),
        .field_code     (field_code),
        .channel        (channel),
        .value          (value),
        .timing         (timing),
        .sample         (sample),
        .last_of_record (last_of_record)
    );

endmodule

`default_nettype wire

>>> rtl/core/derd_queue.sv
// Short queue of classified bytes between the front and back parts.
`default_nettype none

module derd_queue (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push,
    input  derd_pkg::derd_op_t  push_op,
    output logic                full,
    input  wire                 pop,
    output logic                head_valid,
    output derd_pkg::derd_op_t  head_op
);
    import derd_pkg::*;

    derd_op_t            mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_op    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/derd_front.sv
// Front part: tracks the byte position in the record and classifies each byte.
`default_nettype none

module derd_front #(
    parameter int CHANNELS     = 32,
    parameter int HEADER_BYTES = 64,
    parameter int WAVE_SAMPLES = 1023
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 cfg_write,
    input  wire                 cfg_data,
    input  wire                 accept,
    input  wire  [7:0]          data_byte,
    output derd_pkg::derd_op_t  op
);
    import derd_pkg::*;

    localparam int FAST_LEN = HEADER_BYTES + CHANNELS * 6;
    localparam int WAVE_LEN = HEADER_BYTES + WAVE_SAMPLES * CHANNELS * 2;
    localparam int MAX_LEN  = (FAST_LEN > WAVE_LEN) ? FAST_LEN : WAVE_LEN;
    localparam int POS_W    = $clog2(MAX_LEN);
    localparam int CH_W     = $clog2(CHANNELS + 1);
    localparam int IDX_W    = (WAVE_SAMPLES > 1) ? $clog2(WAVE_SAMPLES) : 1;

    logic               mode_reg, mode_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [2:0]         slot_reg, slot_next;      // byte within a fast channel group
    logic [CH_W-1:0]    chan_reg, chan_next;      // current channel, 1-based
    logic               odd_reg, odd_next;        // high byte of a waveform word
    logic [IDX_W-1:0]   idx_reg, idx_next;

    logic               in_header;
    logic               rec_last;
    hdr_info_t          hdr;

    assign in_header = (pos_reg < POS_W'(HEADER_BYTES));
    assign rec_last  = mode_reg ? (pos_reg == POS_W'(FAST_LEN - 1))
                                : (pos_reg == POS_W'(WAVE_LEN - 1));
    assign hdr       = hdr_decode(pos_reg[5:0]);

    // Classification of the byte at the current position.
    always_comb
    begin
        op         = '0;
        op.op      = OP_SKIP;
        op.data    = data_byte;
        op.last    = rec_last;
        if (in_header)
        begin
            if (pos_reg < POS_W'(HDR_USED))
            begin
                if (hdr.used)
                begin
                    op.op         = OP_HEADER;
                    op.hdr_first  = hdr.first;
                    op.hdr_emit   = hdr.emit;
                    op.hdr_time   = hdr.is_time;
                    op.shift      = hdr.shift;
                    op.field_code = 10'(hdr.field);
                end
                else if (hdr.fine)
                begin
                    op.op = OP_FINE;
                end
            end
        end
        else if (mode_reg)
        begin
            op.channel = 6'(chan_reg);
            case (slot_reg)
                3'd1:    op.op = OP_ENERGY_LO;
                3'd3:    op.op = OP_ENERGY_HI;
                3'd5:    op.op = OP_FAST_EMIT;
                default: op.op = OP_LOW;
            endcase
        end
        else
        begin
            op.channel    = 6'(chan_reg);
            op.field_code = 10'(idx_reg);
            op.op         = odd_reg ? OP_WAVE_EMIT : OP_LOW;
        end
    end

    // Position and payload counters.
    always_comb
    begin
        mode_next = mode_reg;
        pos_next  = pos_reg;
        slot_next = slot_reg;
        chan_next = chan_reg;
        odd_next  = odd_reg;
        idx_next  = idx_reg;
        if (cfg_write)
        begin
            mode_next = cfg_data;
            pos_next  = '0;
            slot_next = '0;
            chan_next = CH_W'(1);
            odd_next  = 1'b0;
            idx_next  = '0;
        end
        else if (accept)
        begin
            if (rec_last)
            begin
                pos_next  = '0;
                slot_next = '0;
                chan_next = CH_W'(1);
                odd_next  = 1'b0;
                idx_next  = '0;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
                if (!in_header)
                begin
                    if (mode_reg)
                    begin
                        if (slot_reg == 3'd5)
                        begin
                            slot_next = '0;
                            chan_next = chan_reg + 1'b1;
                        end
                        else
                        begin
                            slot_next = slot_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        odd_next = !odd_reg;
                        if (odd_reg)
                        begin
                            if (chan_reg == CH_W'(CHANNELS))
                            begin
                                chan_next = CH_W'(1);
                                idx_next  = idx_reg + 1'b1;
                            end
                            else
                            begin
                                chan_next = chan_reg + 1'b1;
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b1;
            pos_reg  <= '0;
            slot_reg <= '0;
            chan_reg <= CH_W'(1);
            odd_reg  <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            pos_reg  <= pos_next;
            slot_reg <= slot_next;
            chan_reg <= chan_next;
            odd_reg  <= odd_next;
            idx_reg  <= idx_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/derd_back.sv
// Back part: builds fields from classified bytes and registers the results.
`default_nettype none

module derd_back (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 op_valid,
    input  derd_pkg::derd_op_t  op,
    output logic                op_pop,
    output logic                result_valid,
    input  wire                 result_stall,
    output logic [1:0]          item_kind,
    output logic [9:0]          field_code,
    output logic [5:0]          channel,
    output logic [57:0]         value,
    output logic [15:0]         timing,
    output logic signed [15:0]  sample,
    output logic                last_of_record
);
    import derd_pkg::*;

    typedef struct packed {
        kind_t        kind;
        logic [9:0]   code;
        logic [5:0]   chan;
        logic [47:0]  raw;
        logic [7:0]   fine;
        logic         is_time;
        logic [15:0]  timing;
        logic [15:0]  smp;
        logic         last;
    } exec_t;

    typedef struct packed {
        kind_t        kind;
        logic [9:0]   code;
        logic [5:0]   chan;
        logic [57:0]  value;
        logic [15:0]  timing;
        logic [15:0]  smp;
        logic         last;
    } result_t;

    logic [47:0]  acc_reg, acc_next;
    logic [7:0]   fine_reg, fine_next;
    logic [7:0]   low_reg, low_next;
    logic [31:0]  energy_reg, energy_next;
    logic         exec_valid_reg, exec_valid_next;
    exec_t        exec_reg, exec_next;
    logic         out_valid_reg, out_valid_next;
    result_t      out_reg, out_next;

    logic         out_ready;
    logic         exec_ready;
    logic [15:0]  word;
    logic [47:0]  acc_new;
    logic [57:0]  coarse;
    logic [57:0]  coarse_ns;
    logic [57:0]  fine_ns;

    assign out_ready  = !out_valid_reg || !result_stall;
    assign exec_ready = !exec_valid_reg || out_ready;
    assign op_pop     = op_valid && exec_ready;
    assign word       = {op.data, low_reg};
    assign acc_new    = (op.hdr_first ? 48'd0 : acc_reg) | (48'(op.data) << {op.shift, 3'b000});

    // Execute stage: update the holds and form the raw result.
    always_comb
    begin
        acc_next        = acc_reg;
        fine_next       = fine_reg;
        low_next        = low_reg;
        energy_next     = energy_reg;
        exec_next       = exec_reg;
        exec_valid_next = out_ready ? 1'b0 : exec_valid_reg;
        if (op_pop)
        begin
            exec_next       = '0;
            exec_next.code  = op.field_code;
            exec_next.chan  = op.channel;
            exec_next.last  = op.last;
            exec_valid_next = 1'b0;
            case (op.op)
                OP_FINE:
                begin
                    fine_next = op.data;
                end
                OP_HEADER:
                begin
                    acc_next          = acc_new;
                    exec_next.kind    = KIND_HEADER;
                    exec_next.raw     = acc_new;
                    exec_next.fine    = fine_reg;
                    exec_next.is_time = op.hdr_time;
                    exec_valid_next   = op.hdr_emit;
                end
                OP_LOW:
                begin
                    low_next = op.data;
                end
                OP_ENERGY_LO:
                begin
                    energy_next = {16'd0, word};
                end
                OP_ENERGY_HI:
                begin
                    energy_next = {word, energy_reg[15:0]};
                end
                OP_FAST_EMIT:
                begin
                    exec_next.kind   = KIND_FAST;
                    exec_next.raw    = 48'(energy_reg);
                    exec_next.timing = word;
                    exec_valid_next  = 1'b1;
                end
                OP_WAVE_EMIT:
                begin
                    exec_next.kind  = KIND_WAVE;
                    exec_next.smp   = word;
                    exec_valid_next = 1'b1;
                end
                default:
                begin
                    exec_valid_next = 1'b0;
                end
            endcase
        end
    end

    // Time in ns: coarse * 1000 as 1024 - 32 + 8, fine * 11 as 8 + 2 + 1.
    assign coarse    = 58'(exec_reg.raw);
    assign coarse_ns = (coarse << 10) - (coarse << 5) + (coarse << 3);
    assign fine_ns   = 58'({exec_reg.fine, 3'b000}) + 58'({exec_reg.fine, 1'b0})
                     + 58'(exec_reg.fine);

    // Output stage.
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = exec_valid_reg;
            out_next.kind   = exec_reg.kind;
            out_next.code   = exec_reg.code;
            out_next.chan   = exec_reg.chan;
            out_next.value  = exec_reg.is_time ? coarse_ns + fine_ns : coarse;
            out_next.timing = exec_reg.timing;
            out_next.smp    = exec_reg.smp;
            out_next.last   = exec_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exec_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            exec_valid_reg <= exec_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        fine_reg   <= fine_next;
        low_reg    <= low_next;
        energy_reg <= energy_next;
        exec_reg   <= exec_next;
        out_reg    <= out_next;
    end

    assign result_valid   = out_valid_reg;
    assign item_kind      = out_reg.kind;
    assign field_code     = out_reg.code;
    assign channel        = out_reg.chan;
    assign value          = out_reg.value;
    assign timing         = out_reg.timing;
    assign sample         = out_reg.smp;
    assign last_of_record = out_reg.last;

endmodule

`default_nettype wire

>>> bench/daq_event_record_decoder_test.sv
// Self-checking testbench for the detector readout record decoder.
module daq_event_record_decoder_test;

    import derd_pkg::*;

    // Values of the record_mode register.
    localparam logic MODE_WAVE = 1'b0;
    localparam logic MODE_FAST = 1'b1;

    // Record layout at the block's default parameters.
    localparam int HEADER_LEN     = 64;
    localparam int CHANNEL_CNT    = 32;
    localparam int SAMPLES_PER_CH = 1023;
    localparam int FAST_RECORD    = HEADER_LEN + CHANNEL_CNT * 6;
    localparam int WAVE_RECORD    = HEADER_LEN + SAMPLES_PER_CH * CHANNEL_CNT * 2;

    // Cycles allowed for bytes that give no result to leave the queue and the
    // pipeline (four queue entries, execute stage and output register).
    localparam int SETTLE_CYCLES = 16;

    // The run should take a few thousand time units; this is far beyond.
    localparam int TIMEOUT = 4000000;

    // One decoded result as it should appear on the result channel.
    typedef struct {
        kind_t       kind;
        logic [9:0]  code;
        logic [5:0]  chan;
        logic [57:0] val;
        logic [15:0] tword;
        logic [15:0] smp;
        logic        last;
    } decoded_item_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_write = 1'b0;
    logic               cfg_data = 1'b0;
    logic               byte_valid = 1'b0;
    logic               byte_stall;
    logic [7:0]         data_byte = 8'h00;
    logic               result_valid;
    logic               result_stall = 1'b0;
    logic [1:0]         item_kind;
    logic [9:0]         field_code;
    logic [5:0]         channel;
    logic [57:0]        value;
    logic [15:0]        timing;
    logic signed [15:0] sample;
    logic               last_of_record;

    // Our own copy of the decoder state, advanced on every byte transfer.
    logic        mode_reg = MODE_FAST;
    int          rec_pos = 0;
    logic [47:0] field_acc = '0;
    logic [7:0]  fine_hold = '0;
    logic [7:0]  low_hold = '0;
    logic [31:0] energy_acc = '0;

    // Results predicted but not yet seen, oldest first.
    decoded_item_t pending_items[$];

    int   errors = 0;
    int   stall_left = 0;
    // When set, neither side idles; used for a stretch of back-to-back transfers.
    logic steady = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    daq_event_record_decoder i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_data       (cfg_data),
        .byte_valid     (byte_valid),
        .byte_stall     (byte_stall),
        .data_byte      (data_byte),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .item_kind      (item_kind),
        .field_code     (field_code),
        .channel        (channel),
        .value          (value),
        .timing         (timing),
        .sample         (sample),
        .last_of_record (last_of_record)
    );

    // Works out what one transferred byte does to the decoder state and
    // queues the result that it completes, if any.
    task automatic predict_byte(input logic [7:0] b);
        decoded_item_t r;
        int            rec_len;
        int            off;
        int            first_pos;
        int            last_pos;
        int            s;
        logic [3:0]    fld;
        logic          in_field;
        logic          is_time;
        logic          at_end;
        logic [15:0]   word;
        rec_len = (mode_reg == MODE_FAST) ? FAST_RECORD : WAVE_RECORD;
        at_end  = (rec_pos + 1 >= rec_len);
        r.kind  = KIND_HEADER;
        r.code  = '0;
        r.chan  = '0;
        r.val   = '0;
        r.tword = '0;
        r.smp   = '0;
        r.last  = at_end;
        if (rec_pos < HEADER_LEN)
        begin
            // Locate the header field that this byte belongs to. The first byte
            // of each time field is its fine part and belongs to no field.
            in_field  = 1'b1;
            is_time   = 1'b0;
            first_pos = 0;
            last_pos  = 0;
            fld       = FLD_DATA_LENGTH;
            if (rec_pos <= 3)
            begin
                fld = FLD_DATA_LENGTH; first_pos = 0; last_pos = 3;
            end
            else if (rec_pos <= 5)
            begin
                fld = FLD_RUN_NUMBER; first_pos = 4; last_pos = 5;
            end
            else if (rec_pos == 6)
            begin
                fld = FLD_TRIG_TYPE; first_pos = 6; last_pos = 6;
            end
            else if (rec_pos <= 10)
            begin
                fld = FLD_TRIG_NUMBER; first_pos = 7; last_pos = 10;
            end
            else if (rec_pos == 11 || rec_pos == 27)
            begin
                in_field  = 1'b0;
                fine_hold = b;
            end
            else if (rec_pos <= 17)
            begin
                fld = FLD_TRIG_TIME; first_pos = 12; last_pos = 17; is_time = 1'b1;
            end
            else if (rec_pos == 18)
            begin
                fld = FLD_MODULE_ID; first_pos = 18; last_pos = 18;
            end
            else if (rec_pos <= 22)
            begin
                fld = FLD_LOCAL_NUMBER; first_pos = 19; last_pos = 22;
            end
            else if (rec_pos <= 26)
            begin
                fld = FLD_LOCAL_PATTERN; first_pos = 23; last_pos = 26;
            end
            else if (rec_pos <= 33)
            begin
                fld = FLD_LOCAL_TIME; first_pos = 28; last_pos = 33; is_time = 1'b1;
            end
            else
            begin
                // Bytes 34 to the end of the header are skipped.
                in_field = 1'b0;
            end

            if (in_field)
            begin
                if (rec_pos == first_pos)
                    field_acc = '0;
                field_acc = field_acc | (48'(b) << (8 * (rec_pos - first_pos)));
                if (rec_pos == last_pos)
                begin
                    r.code = 10'(fld);
                    r.last = 1'b0;
                    // Times are given in ns: coarse ticks of 1000 ns, fine of 11 ns.
                    if (is_time)
                        r.val = 58'(field_acc) * 58'd1000 + 58'(fine_hold) * 58'd11;
                    else
                        r.val = 58'(field_acc);
                    pending_items.push_back(r);
                end
            end
        end
        else
        begin
            // Payload: little-endian 16-bit words, the low byte held until
            // the high byte arrives.
            off = rec_pos - HEADER_LEN;
            if (off % 2 == 0)
            begin
                low_hold = b;
            end
            else
            begin
                word = {b, low_hold};
                if (mode_reg == MODE_FAST)
                begin
                    // Each channel is energy low, energy high, then timing.
                    case (off % 6)
                        1:
                        begin
                            energy_acc = {16'h0000, word};
                        end
                        3:
                        begin
                            energy_acc = {word, energy_acc[15:0]};
                        end
                        default:
                        begin
                            r.kind  = KIND_FAST;
                            r.chan  = 6'(off / 6 + 1);
                            r.val   = 58'(energy_acc);
                            r.tword = word;
                            pending_items.push_back(r);
                        end
                    endcase
                end
                else
                begin
                    // Samples are interleaved: all channels of index 0 first.
                    s      = off / 2;
                    r.kind = KIND_WAVE;
                    r.code = 10'(s / CHANNEL_CNT);
                    r.chan = 6'(s % CHANNEL_CNT + 1);
                    r.smp  = word;
                    pending_items.push_back(r);
                end
            end
        end
        rec_pos = at_end ? 0 : rec_pos + 1;
    endtask

    // Offers one byte, idling now and then beforehand, and waits for its
    // transfer. Valid is left high so that back-to-back bytes need no gap.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (!steady && $urandom_range(99) < 18)
        begin
            gap = $urandom_range(3, 1);
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid <= 1'b1;
        data_byte  <= b;
        do
            @(posedge clk);
        while (byte_stall);
        predict_byte(b);
    endtask

    // Random bytes, weighted towards all-zeros and all-ones.
    function automatic logic [7:0] pick_byte();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return 8'h00;
        if (roll < 20)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    task automatic send_random(input int count);
        repeat (count) send_byte(pick_byte());
    endtask

    // Stops offering bytes until every predicted result has arrived, then
    // lets bytes that give no result drain from the pipeline.
    task automatic drain_results();
        byte_valid <= 1'b0;
        while (pending_items.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes record_mode once the block is idle. Any write restarts the record.
    task automatic write_mode(input logic m);
        drain_results();
        cfg_write <= 1'b1;
        cfg_data  <= m;
        @(posedge clk);
        cfg_write <= 1'b0;
        mode_reg = m;
        rec_pos  = 0;
    endtask

    task automatic test_header_extremes();
        // Reset leaves the block in fast mode. All fields up to the trigger
        // time are sent at their maximum, the module id at zero.
        repeat (18) send_byte(8'hFF);
        send_byte(8'h00);
        // A mode write part-way through the header must restart the record.
        write_mode(MODE_FAST);
        repeat (4) send_byte(8'h00);
    endtask

    task automatic test_fast_records();
        write_mode(MODE_FAST);
        send_random(HEADER_LEN);
        // Channel 1 at full energy and timing, channel 2 at zero.
        repeat (6) send_byte(8'hFF);
        repeat (6) send_byte(8'h00);
        send_random(8 * 6);
        // The sender holds off here until the result channel is empty.
        drain_results();
        // Stop short of the record end, which the steady stream crosses.
        send_random(FAST_RECORD - HEADER_LEN - 10 * 6 - 56);
    endtask

    task automatic test_steady_stream();
        // The end of a fast record and the start of the next with no idling on
        // either side; the record wraps back to byte 0 mid-stream.
        steady = 1'b1;
        send_random(100);
        steady = 1'b0;
    endtask

    task automatic test_waveform_record();
        // Switching to waveform mode abandons the fast record in progress.
        write_mode(MODE_WAVE);
        send_random(HEADER_LEN);
        // Sample extremes: most negative, most positive, minus one and zero.
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(8'hFF);
        send_byte(8'h7F);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h00);
        // Enough samples to move past the first sample index of all channels.
        send_random(120);
    endtask

    task automatic test_mode_changes();
        // Abort the waveform record part-way through its payload.
        write_mode(MODE_FAST);
        send_random(HEADER_LEN + 12);
        write_mode(MODE_WAVE);
        send_random(20);
        // Abort the waveform record part-way through its header.
        write_mode(MODE_FAST);
        send_random(40);
    endtask

    // The receiver stalls in random bursts, so that the queue inside the block
    // fills and the byte channel is stalled in turn.
    always @(posedge clk)
    begin
        if (steady)
        begin
            stall_left   <= 0;
            result_stall <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left   <= stall_left - 1;
            result_stall <= 1'b1;
        end
        else if ($urandom_range(99) < 10)
        begin
            stall_left   <= $urandom_range(5);
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= 1'b0;
        end
    end

    task automatic compare_field(input string name, input logic [57:0] want,
                                 input logic [57:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors = errors + 1;
        end
    endtask

    // Every result transfer is matched against the oldest prediction.
    always @(posedge clk)
    begin
        decoded_item_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_items.size() == 0)
            begin
                $error("result transfer with none expected: kind %0d code %0d channel %0d",
                       item_kind, field_code, channel);
                errors = errors + 1;
            end
            else
            begin
                want = pending_items.pop_front();
                compare_field("item_kind", 58'(want.kind), 58'(item_kind));
                compare_field("field_code", 58'(want.code), 58'(field_code));
                compare_field("channel", 58'(want.chan), 58'(channel));
                compare_field("value", want.val, value);
                compare_field("timing", 58'(want.tword), 58'(timing));
                compare_field("sample", 58'(want.smp), 58'(sample[15:0]));
                compare_field("last_of_record", 58'(want.last), 58'(last_of_record));
            end
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_header_extremes();
        test_fast_records();
        test_steady_stream();
        test_waveform_record();
        test_mode_changes();
        drain_results();
        if (errors == 0 && pending_items.size() == 0)
            $display("PASS daq_event_record_decoder");
        else
            $display("FAIL daq_event_record_decoder");
        $finish;
    end

    // Guards against a hung handshake.
    initial
    begin
        #(TIMEOUT);
        $display("FAIL daq_event_record_decoder");
        $finish;
    end

endmodule
